>>> src/safu_pkg.sv
package safu_pkg;

  localparam int DATA_W = 24;
  localparam int FRAC_W = 16;
  localparam int IQ     = 32;

  localparam logic [32:0] TQ       = 33'h1_0000_0000;
  localparam logic [31:0] LN2_Q32  = 32'd2977044472;
  localparam logic [31:0] SELU_Q31 = 32'd2256361069;
  localparam logic [22:0] ARG_LIM  = 23'(64 << FRAC_W);
  localparam logic [23:0] ONE      = 24'(1 << FRAC_W);

  localparam logic [3:0] FN_TANH     = 4'd0;
  localparam logic [3:0] FN_SIGMOID  = 4'd1;
  localparam logic [3:0] FN_RELU     = 4'd2;
  localparam logic [3:0] FN_LEAKY    = 4'd3;
  localparam logic [3:0] FN_SWISH    = 4'd4;
  localparam logic [3:0] FN_SOFTPLUS = 4'd5;
  localparam logic [3:0] FN_SOFTSIGN = 4'd6;
  localparam logic [3:0] FN_BENT     = 4'd7;
  localparam logic [3:0] FN_HARDTANH = 4'd8;
  localparam logic [3:0] FN_SELU     = 4'd9;
  localparam logic [3:0] FN_ELU      = 4'd10;
  localparam logic [3:0] FN_LOGISTIC = 4'd11;

  localparam logic REG_FSEL  = 1'b0;
  localparam logic REG_SLOPE = 1'b1;

  localparam logic [3:0]  FSEL_RST  = FN_SIGMOID;
  localparam logic [15:0] SLOPE_RST = 16'd6554;

  typedef struct packed {
    logic [3:0]                fsel;
    logic signed [DATA_W-1:0]  x;
    logic                      neg;
    logic [DATA_W-1:0]         ax;
    logic [38:0]               xi;
    logic [DATA_W-1:0]         bigv;
    logic [16:0]               smlv;
    logic [39:0]               a;
    logic [7:0]                k;
    logic [31:0]               f;
    logic [31:0]               term;
    logic signed [34:0]        esum;
    logic [32:0]               e;
    logic [33:0]               dd;
    logic [34:0]               dr;
    logic [32:0]               dq;
    logic [32:0]               q1;
    logic [63:0]               sq;
    logic [31:0]               pp;
    logic [33:0]               ps;
    logic [63:0]               sv;
    logic [63:0]               sr;
    logic [41:0]               mm;
    logic signed [41:0]        r;
  } item_t;

endpackage

>>> src/selectable_activation_function_unit.sv
// Activation unit for signed Q7.16 values, one item per clock. An item is taken at every
// edge where start is high; busy never rises. Each item passes a fixed 107-stage pipeline
// and an output register; its result appears on the result ports for one cycle with
// done_o high, in input order. The depth is set by the 14-term exp series (two stages a
// term after the first, which rides on the range reduction), the two 32-bit restoring
// dividers (two quotient bits a stage), the 12-term log series and the 32-step square
// root. There is no way to hold results off: the receiver must take done_o cycles as they
// come. The user must write function_select and leaky_slope over the APB port only while
// no item is in flight; the block itself does not enforce this.
module selectable_activation_function_unit import safu_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] pre_activation_i,
  output logic                     done_o,
  output logic signed [DATA_W-1:0] activation_o,
  output logic                     saturated_o,
  output logic                     bad_select_o
);

  localparam int N_KS   = 2;
  localparam int N_TERM = 26;
  localparam int N_DIV  = 16;
  localparam int N_SER  = 24;
  localparam int N_SQRT = 16;

  localparam int S_KS    = 1;
  localparam int S_TERM  = S_KS + N_KS;
  localparam int S_EXPF  = S_TERM + N_TERM;
  localparam int S_PREP1 = S_EXPF + 1;
  localparam int S_DIV1  = S_PREP1 + 1;
  localparam int S_SQ    = S_DIV1 + N_DIV;
  localparam int S_SER   = S_SQ + 1;
  localparam int S_SQRT  = S_SER + N_SER;
  localparam int S_PREP2 = S_SQRT + N_SQRT;
  localparam int S_DIV2  = S_PREP2 + 1;
  localparam int S_MUL   = S_DIV2 + N_DIV;
  localparam int S_CONV  = S_MUL + 1;
  localparam int NST     = S_CONV + 1;

  localparam logic signed [41:0] MAXV = 42'sd8388607;
  localparam logic signed [41:0] MINV = -42'sd8388608;

  logic [3:0]  fsel_q;
  logic [15:0] slope_q;
  logic        accept;

  item_t           in_d;
  item_t           pipe_q [NST];
  logic [NST-1:0]  vld_q;

  logic signed [DATA_W-1:0] act_q;
  logic                     sat_q;
  logic                     bad_q;
  logic                     done_q;
  logic signed [DATA_W-1:0] act_d;
  logic                     sat_d;
  logic                     bad_d;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign prdata = (paddr[2] == REG_SLOPE) ? {16'b0, slope_q} : {28'b0, fsel_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsel_q  <= FSEL_RST;
      slope_q <= SLOPE_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_FSEL) begin
        fsel_q <= pwdata[3:0];
      end else begin
        slope_q <= pwdata[15:0];
      end
    end
  end

  function automatic item_t f_ks(item_t s, int base);
    item_t       o;
    logic [39:0] c;
    o = s;
    for (int j = 3; j >= 0; j--) begin
      c = 40'(LN2_Q32) << (base + j);
      if (o.a >= c) begin
        o.a = o.a - c;
        o.k[base+j] = 1'b1;
      end
    end
    if (base == 0) begin
      o.f    = o.a[31:0];
      o.term = o.a[31:0];
      o.esum = $signed({2'b0, TQ}) - $signed({3'b0, o.a[31:0]});
    end
    return o;
  endfunction

  function automatic item_t f_tmul(item_t s);
    item_t o;
    o = s;
    o.term = 32'((64'(s.term) * 64'(s.f)) >> IQ);
    return o;
  endfunction

  function automatic item_t f_tdiv(item_t s, logic [32:0] mg, int sh, logic odd);
    item_t       o;
    logic [64:0] p;
    logic [31:0] q;
    o = s;
    p = 65'(s.term) * 65'(mg);
    q = 32'(p >> sh);
    o.term = q;
    o.esum = odd ? s.esum - $signed({3'b0, q}) : s.esum + $signed({3'b0, q});
    return o;
  endfunction

  function automatic item_t f_expf(item_t s);
    item_t       o;
    logic [33:0] s0;
    logic [34:0] sh;
    o  = s;
    s0 = s.esum[34] ? '0 : s.esum[33:0];
    sh = {s0, 1'b0} >> s.k;
    o.e = (s.k >= 8'd40) ? '0 : 33'((36'(sh) + 36'd1) >> 1);
    return o;
  endfunction

  function automatic item_t f_prep1(item_t s);
    item_t       o;
    logic [33:0] n;
    logic [33:0] d;
    o = s;
    case (s.fsel)
      FN_TANH: begin
        n = 34'(TQ - s.e);
        d = 34'(TQ) + 34'(s.e);
      end
      FN_SIGMOID, FN_LOGISTIC, FN_SWISH: begin
        n = 34'(TQ);
        d = 34'(TQ) + 34'(s.e);
      end
      FN_SOFTPLUS: begin
        n = 34'(s.e);
        d = {TQ, 1'b0} + 34'(s.e);
      end
      FN_SOFTSIGN: begin
        n = 34'(s.ax);
        d = 34'(s.ax) + 34'(ONE);
      end
      FN_BENT: begin
        n = 34'(s.smlv);
        d = 34'(s.bigv);
      end
      default: begin
        n = '0;
        d = 34'd1;
      end
    endcase
    o.dd = d;
    if (n >= d) begin
      o.dq = 33'd1;
      o.dr = 35'(n - d);
    end else begin
      o.dq = '0;
      o.dr = 35'(n);
    end
    return o;
  endfunction

  function automatic item_t f_div(item_t s);
    item_t       o;
    logic [34:0] r2;
    o = s;
    for (int j = 0; j < 2; j++) begin
      r2 = {o.dr[33:0], 1'b0};
      if (r2 >= {1'b0, o.dd}) begin
        o.dr = r2 - {1'b0, o.dd};
        o.dq = {o.dq[31:0], 1'b1};
      end else begin
        o.dr = r2;
        o.dq = {o.dq[31:0], 1'b0};
      end
    end
    return o;
  endfunction

  function automatic item_t f_sq(item_t s);
    item_t       o;
    logic [31:0] op;
    o    = s;
    o.q1 = s.dq;
    op   = (s.fsel == FN_BENT) ? s.dq[32:1] : s.dq[31:0];
    o.sq = 64'(op) * 64'(op);
    o.pp = s.dq[31:0];
    o.ps = '0;
    return o;
  endfunction

  function automatic item_t f_sdiv(item_t s, logic [32:0] mg, int sh, logic first);
    item_t       o;
    logic [64:0] p;
    o = s;
    p = 65'(s.pp) * 65'(mg);
    o.ps = s.ps + 34'(p >> sh);
    if (first) begin
      o.sv = 64'h4000_0000_0000_0000 + s.sq;
      o.sr = '0;
    end
    return o;
  endfunction

  function automatic item_t f_smul(item_t s);
    item_t o;
    o = s;
    o.pp = 32'((64'(s.pp) * 64'(s.sq[63:32])) >> IQ);
    return o;
  endfunction

  function automatic item_t f_sqrt(item_t s, int base);
    item_t       o;
    logic [63:0] b;
    o = s;
    for (int j = 0; j < 2; j++) begin
      b = 64'd1 << (62 - 2 * (base + j));
      if (o.sv >= o.sr + b) begin
        o.sv = o.sv - (o.sr + b);
        o.sr = (o.sr >> 1) + b;
      end else begin
        o.sr = o.sr >> 1;
      end
    end
    return o;
  endfunction

  function automatic item_t f_prep2(item_t s);
    item_t o;
    o = s;
    o.dd = 34'(33'h0_8000_0000 + 33'(s.sr[31:0]));
    o.dr = {3'b0, s.q1[32:1]};
    o.dq = '0;
    return o;
  endfunction

  function automatic item_t f_mul(item_t s, logic [15:0] slope);
    item_t       o;
    logic [38:0] a;
    logic [32:0] b;
    logic [15:0] bias;
    logic [7:0]  hi;
    logic [31:0] lo;
    int          sh;
    o    = s;
    bias = '0;
    sh   = 32;
    case (s.fsel)
      FN_SWISH: begin
        a = s.xi;
        b = s.neg ? TQ - s.q1 : s.q1;
      end
      FN_SELU: begin
        a  = s.neg ? 39'(TQ - s.e) : 39'(s.ax);
        b  = 33'(SELU_Q31);
        sh = 31;
      end
      FN_BENT: begin
        a  = 39'(s.smlv);
        b  = {1'b0, s.dq[32:1]};
        sh = 31;
      end
      FN_LEAKY: begin
        a    = 39'(s.ax);
        b    = 33'(slope);
        sh   = 16;
        bias = 16'hFFFF;
      end
      default: begin
        a = '0;
        b = '0;
      end
    endcase
    hi   = 8'(a >> sh);
    lo   = 32'(a & ((39'd1 << sh) - 39'd1));
    o.mm = 42'(41'(hi) * 41'(b)) + 42'((65'(lo) * 65'(b) + 65'(bias)) >> sh);
    return o;
  endfunction

  function automatic logic signed [41:0] tn(logic signed [43:0] v);
    return 42'((v + 44'sd32768) >>> FRAC_W);
  endfunction

  function automatic item_t f_conv(item_t s);
    item_t              o;
    logic signed [41:0] xs;
    logic signed [41:0] px;
    logic signed [43:0] q1s;
    logic signed [43:0] mms;
    logic signed [43:0] tq44;
    logic signed [41:0] ms;
    logic [41:0]        root;
    logic [41:0]        bnt;
    o    = s;
    xs   = 42'(s.x);
    px   = s.neg ? '0 : xs;
    q1s  = $signed({11'b0, s.q1});
    mms  = $signed({2'b0, s.mm});
    tq44 = $signed({11'b0, TQ});
    ms   = $signed({25'b0, s.q1[32:16]});
    root = 42'(s.bigv) + s.mm;
    bnt  = (root - 42'(ONE)) >> 1;
    case (s.fsel)
      FN_TANH:                 o.r = tn(s.neg ? -q1s : q1s);
      FN_SIGMOID, FN_LOGISTIC: o.r = tn(s.neg ? tq44 - q1s : q1s);
      FN_RELU:                 o.r = px;
      FN_LEAKY:                o.r = s.neg ? 42'(-mms) : xs;
      FN_SWISH: begin
        if (s.ax >= 24'(ARG_LIM)) begin
          o.r = px;
        end else begin
          o.r = tn(s.neg ? -mms : mms);
        end
      end
      FN_SOFTPLUS:             o.r = px + tn($signed({9'b0, s.ps, 1'b0}));
      FN_SOFTSIGN:             o.r = s.neg ? -ms : ms;
      FN_BENT:                 o.r = xs + $signed(bnt);
      FN_HARDTANH: begin
        if (xs > 42'sd65536) begin
          o.r = 42'sd65536;
        end else if (xs < -42'sd65536) begin
          o.r = -42'sd65536;
        end else begin
          o.r = xs;
        end
      end
      FN_SELU:                 o.r = s.neg ? tn(-mms) : 42'(mms);
      FN_ELU:                  o.r = s.neg ? tn($signed({11'b0, s.e}) - tq44) : xs;
      default:                 o.r = '0;
    endcase
    return o;
  endfunction

  always_comb begin
    logic [22:0] cl;
    in_d      = '0;
    in_d.fsel = fsel_q;
    in_d.x    = pre_activation_i;
    in_d.neg  = pre_activation_i[DATA_W-1];
    in_d.ax   = in_d.neg ? (~pre_activation_i + 24'd1) : pre_activation_i;
    cl        = (in_d.ax < 24'(ARG_LIM)) ? in_d.ax[22:0] : ARG_LIM;
    in_d.xi   = {cl, 16'b0};
    in_d.bigv = (in_d.ax > ONE) ? in_d.ax : ONE;
    in_d.smlv = (in_d.ax > ONE) ? ONE[16:0] : in_d.ax[16:0];
    in_d.a    = (fsel_q == FN_TANH) ? {in_d.xi, 1'b0} : {1'b0, in_d.xi};
  end

  always_ff @(posedge clk_i) begin
    pipe_q[0] <= in_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NST-2:0], accept};
    end
  end

  for (genvar i = 1; i < NST; i++) begin : g_st
    item_t stage_d;
    if (i < S_TERM) begin : g_ks
      always_comb stage_d = f_ks(pipe_q[i-1], (i == S_KS) ? 4 : 0);
    end else if (i < S_EXPF) begin : g_term
      localparam int N  = 2 + (i - S_TERM) / 2;
      localparam int SH = 32 + $clog2(N);
      localparam logic [32:0] MG = 33'(((65'd1 << SH) + 65'(N) - 65'd1) / 65'(N));
      if ((i - S_TERM) % 2 == 0) begin : g_m
        always_comb stage_d = f_tmul(pipe_q[i-1]);
      end else begin : g_d
        always_comb stage_d = f_tdiv(pipe_q[i-1], MG, SH, (N % 2) == 1);
      end
    end else if (i == S_EXPF) begin : g_expf
      always_comb stage_d = f_expf(pipe_q[i-1]);
    end else if (i == S_PREP1) begin : g_p1
      always_comb stage_d = f_prep1(pipe_q[i-1]);
    end else if (i < S_SQ) begin : g_div1
      always_comb stage_d = f_div(pipe_q[i-1]);
    end else if (i == S_SQ) begin : g_sq
      always_comb stage_d = f_sq(pipe_q[i-1]);
    end else if (i < S_SQRT) begin : g_ser
      localparam int N  = 2 * ((i - S_SER) / 2) + 1;
      localparam int SH = 32 + $clog2(N);
      localparam logic [32:0] MG = 33'(((65'd1 << SH) + 65'(N) - 65'd1) / 65'(N));
      if ((i - S_SER) % 2 == 0) begin : g_d
        always_comb stage_d = f_sdiv(pipe_q[i-1], MG, SH, i == S_SER);
      end else begin : g_m
        always_comb stage_d = f_smul(pipe_q[i-1]);
      end
    end else if (i < S_PREP2) begin : g_sqrt
      always_comb stage_d = f_sqrt(pipe_q[i-1], 2 * (i - S_SQRT));
    end else if (i == S_PREP2) begin : g_p2
      always_comb stage_d = f_prep2(pipe_q[i-1]);
    end else if (i < S_MUL) begin : g_div2
      always_comb stage_d = f_div(pipe_q[i-1]);
    end else if (i == S_MUL) begin : g_mul
      always_comb stage_d = f_mul(pipe_q[i-1], slope_q);
    end else begin : g_conv
      always_comb stage_d = f_conv(pipe_q[i-1]);
    end
    always_ff @(posedge clk_i) begin
      pipe_q[i] <= stage_d;
    end
  end

  always_comb begin
    item_t lst;
    lst   = pipe_q[NST-1];
    bad_d = lst.fsel inside {[4'd12:4'd15]};
    sat_d = 1'b0;
    if (lst.r > MAXV) begin
      act_d = DATA_W'(MAXV);
      sat_d = 1'b1;
    end else if (lst.r < MINV) begin
      act_d = DATA_W'(MINV);
      sat_d = 1'b1;
    end else begin
      act_d = DATA_W'(lst.r);
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    sat_q <= sat_d;
    bad_q <= bad_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[NST-1];
    end
  end

  assign done_o       = done_q;
  assign activation_o = act_q;
  assign saturated_o  = sat_q;
  assign bad_select_o = bad_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(NST+1) done_o)
    else $error("item did not come out after the pipeline depth");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && bad_select_o |-> activation_o == '0 && !saturated_o)
    else $error("unknown selector gave a nonzero or clamped result");

  a_sat_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && saturated_o |->
      activation_o == 24'sh7FFFFF || activation_o == -24'sh800000)
    else $error("clamp flag without a range limit on the result");

endmodule

>>> sim/selectable_activation_function_unit_test.sv
module selectable_activation_function_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import safu_pkg::*;

  typedef logic [63:0] u64;

  typedef struct {
    logic signed [DATA_W-1:0] act;
    logic                     sat;
    logic                     bad;
  } act_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [2:0]               paddr = '0;
  logic [31:0]              pwdata = '0;
  logic [31:0]              prdata;
  logic                     pready;
  logic                     start = 1'b0;
  logic                     busy;
  logic signed [DATA_W-1:0] pre_activation_i = '0;
  logic                     done_o;
  logic signed [DATA_W-1:0] activation_o;
  logic                     saturated_o;
  logic                     bad_select_o;

  logic [3:0]  cur_fsel = FSEL_RST;
  logic [15:0] cur_slope = SLOPE_RST;
  act_result_t pending_acts[$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          send_idle_pct = 0;

  selectable_activation_function_unit i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .pre_activation_i, .done_o, .activation_o, .saturated_o,
    .bad_select_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic u64 frac_div(u64 n, u64 d, int bits);
    u64 q, r;
    if (d == 0) return 0;
    q = n / d;
    r = n % d;
    for (int i = 0; i < bits; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic u64 mul_shr(u64 a, u64 b, int s);
    u64 hi, lo;
    hi = a >> s;
    lo = a & ((64'd1 << s) - 64'd1);
    return hi * b + ((lo * b) >> s);
  endfunction

  function automatic u64 int_sqrt(u64 v);
    u64 r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic u64 exp_of_neg(u64 a);
    u64     k, f, term;
    longint sum;
    k = a / u64'(LN2_Q32);
    f = a - k * u64'(LN2_Q32);
    term = u64'(TQ);
    sum = longint'(u64'(TQ));
    if (k >= 40) return 0;
    for (int n = 1; n <= 14; n++) begin
      term = ((term * f) >> 32) / u64'(n);
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (k == 0) return u64'(sum);
    return (u64'(sum) + (64'd1 << (k - 1))) >> k;
  endfunction

  function automatic u64 log_one_plus(u64 e);
    u64 z, z2, p, sum;
    z = frac_div(e, 2 * u64'(TQ) + e, 32);
    z2 = (z * z) >> 32;
    p = z;
    sum = 0;
    for (int j = 0; j < 12; j++) begin
      sum = sum + p / u64'(2 * j + 1);
      p = (p * z2) >> 32;
    end
    return 2 * sum;
  endfunction

  function automatic longint q32_to_out(longint v);
    u64 m;
    v = v + (longint'(1) << 15);
    if (v >= 0) return longint'(u64'(v) >> 16);
    m = u64'(-v);
    return -longint'((m + 64'd65535) >> 16);
  endfunction

  function automatic longint bent_fn(longint x, u64 ax);
    u64 one, big, sml, t, g, w, root;
    one = 64'd1 << FRAC_W;
    big = ax > one ? ax : one;
    sml = ax > one ? one : ax;
    t = frac_div(sml, big, 31);
    g = int_sqrt((64'd1 << 62) + t * t);
    w = frac_div(t, (64'd1 << 31) + g, 31);
    root = big + mul_shr(sml, w, 31);
    return x + longint'((root - one) >> 1);
  endfunction

  function automatic act_result_t activate(logic signed [DATA_W-1:0] din, logic [3:0] fsel,
                                           logic [15:0] slope);
    act_result_t res;
    longint      x, r, maxv, minv;
    u64          ax, xi, lim, m, p, tq;
    logic        neg;
    x = din;
    tq = u64'(TQ);
    maxv = (longint'(1) << (DATA_W - 1)) - 1;
    minv = -maxv - 1;
    lim = 64'd64 << FRAC_W;
    neg = x < 0;
    ax = neg ? u64'(-x) : u64'(x);
    xi = (ax < lim ? ax : lim) << 16;
    res.bad = 1'b0;
    res.sat = 1'b0;
    r = 0;
    case (fsel)
      FN_TANH: begin
        p = exp_of_neg(2 * xi);
        m = frac_div(tq - p, tq + p, 32);
        r = q32_to_out(neg ? -longint'(m) : longint'(m));
      end
      FN_SIGMOID, FN_LOGISTIC: begin
        p = frac_div(tq, tq + exp_of_neg(xi), 32);
        r = q32_to_out(longint'(neg ? tq - p : p));
      end
      FN_RELU: r = neg ? 0 : x;
      FN_LEAKY: begin
        if (neg) r = -longint'((ax * u64'(slope) + 64'hFFFF) >> 16);
        else r = x;
      end
      FN_SWISH: begin
        if (ax >= lim) begin
          r = neg ? 0 : x;
        end else begin
          p = frac_div(tq, tq + exp_of_neg(xi), 32);
          m = mul_shr(xi, neg ? tq - p : p, 32);
          r = q32_to_out(neg ? -longint'(m) : longint'(m));
        end
      end
      FN_SOFTPLUS: r = (neg ? 0 : x) + q32_to_out(longint'(log_one_plus(exp_of_neg(xi))));
      FN_SOFTSIGN: begin
        m = frac_div(ax, ax + (64'd1 << FRAC_W), FRAC_W);
        r = neg ? -longint'(m) : longint'(m);
      end
      FN_BENT: r = bent_fn(x, ax);
      FN_HARDTANH: begin
        r = x;
        if (x > (longint'(1) << FRAC_W)) r = longint'(1) << FRAC_W;
        else if (x < -(longint'(1) << FRAC_W)) r = -(longint'(1) << FRAC_W);
      end
      FN_SELU: begin
        if (neg) begin
          m = mul_shr(tq - exp_of_neg(xi), u64'(SELU_Q31), 31);
          r = q32_to_out(-longint'(m));
        end else begin
          r = longint'(mul_shr(ax, u64'(SELU_Q31), 31));
        end
      end
      FN_ELU: begin
        if (neg) r = q32_to_out(longint'(exp_of_neg(xi)) - longint'(tq));
        else r = x;
      end
      default: begin
        res.bad = 1'b1;
        r = 0;
      end
    endcase
    if (r > maxv) begin
      r = maxv;
      res.sat = 1'b1;
    end else if (r < minv) begin
      r = minv;
      res.sat = 1'b1;
    end
    res.act = r[DATA_W-1:0];
    return res;
  endfunction

  // expectations are taken on the accepting edge
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy)
      pending_acts.insert(pending_acts.size(), activate(pre_activation_i, cur_fsel, cur_slope));
  end

  always @(posedge clk_i) begin
    act_result_t want;
    if (rst_ni && done_o) begin
      if (pending_acts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: act=%0d", activation_o);
      end else begin
        want = pending_acts.pop_front();
        if (activation_o !== want.act || saturated_o !== want.sat ||
            bad_select_o !== want.bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: act %0d/%0d sat %b/%b bad %b/%b (expected/actual)",
                     want.act, activation_o, want.sat, saturated_o, want.bad,
                     bad_select_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 5000) begin
      $display("selectable_activation_function_unit regression: fail");
      $finish;
    end
  end

  task automatic send_item(logic signed [DATA_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    pre_activation_i <= v;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_acts.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == {REG_SLOPE, 2'b00}) cur_slope = data[15:0];
    else cur_fsel = data[3:0];
  endtask

  function automatic logic signed [DATA_W-1:0] rand_input();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return $signed(24'($urandom_range(1 << 20))) - 24'sd524288;
      2: return $signed(24'($urandom_range(1 << 17))) - 24'sd65536;
      default: return ($urandom_range(1) ? 24'sd4194304 : -24'sd4194304)
                      + $signed(24'($urandom_range(16))) - 24'sd8;
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_item(24'sd65536);
    send_item(-24'sd65536);
    send_item(24'sd0);
    write_reg({REG_FSEL, 2'b00}, 32'(FN_LEAKY));
    send_item(-24'sd65536);
    send_item(-24'sd8388608);
  endtask

  task automatic test_extremes();
    logic signed [DATA_W-1:0] vals[6] = '{-24'sd8388608, 24'sd8388607, 24'sd0, -24'sd1,
                                          24'sd65536, -24'sd4194304};
    for (int f = 0; f < 16; f++) begin
      write_reg({REG_FSEL, 2'b00}, 32'(f));
      foreach (vals[i]) send_item(vals[i]);
    end
    write_reg({REG_FSEL, 2'b00}, 32'(FN_LEAKY));
    write_reg({REG_SLOPE, 2'b00}, 32'd0);
    send_item(-24'sd8388608);
    write_reg({REG_SLOPE, 2'b00}, 32'hFFFF);
    send_item(-24'sd8388608);
    send_item(-24'sd1);
  endtask

  task automatic test_random(int idle_pct, int count);
    send_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        write_reg({REG_FSEL, 2'b00}, 32'($urandom_range(15)));
        case ($urandom_range(3))
          0: write_reg({REG_SLOPE, 2'b00}, 32'd0);
          1: write_reg({REG_SLOPE, 2'b00}, 32'hFFFF);
          default: write_reg({REG_SLOPE, 2'b00}, 32'($urandom_range(16'hFFFF)));
        endcase
      end
      send_item(rand_input());
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_extremes();
    test_random(10, 330);
    test_random(80, 330);
    test_random(0, 340);
    drain();
    if (mismatches == 0 && pending_acts.size() == 0)
      $display("selectable_activation_function_unit regression: pass");
    else
      $display("selectable_activation_function_unit regression: fail");
    $finish;
  end

endmodule

>>> sim.f
src/safu_pkg.sv
src/selectable_activation_function_unit.sv
sim/selectable_activation_function_unit_test.sv
